// ===== sv/vcd_pkg.sv =====
// ----------------------------------------------------------------------------
// vcd_pkg
// Shared types, widths and helpers for the cell divergence update pipeline.
// ----------------------------------------------------------------------------
package vcd_pkg;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BETA  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BEN   = 2'd2;

	localparam int FRAC_W = 24;
	localparam int PROD_W = 62;                 // |flux| * jacobian, scale * jacobian
	localparam int NUM_W  = PROD_W + FRAC_W;    // dividend and quotient width
	localparam int DEN_W  = PROD_W;
	localparam int TERM_W = NUM_W + 2;          // signed sum of two face terms
	localparam int ACC_W  = NUM_W + 3;          // signed sum of all three terms

	typedef struct packed {
		logic               neg_m;
		logic               neg_p;
		logic               neg_y;
		logic signed [31:0] vold;
		logic signed [31:0] sprev;
	} side_t;

	// zero metric code counts as the smallest positive value
	function automatic logic [30:0] pos31(input logic [30:0] v);
		return (v == 31'd0) ? 31'd1 : v;
	endfunction

endpackage

// ===== sv/vcd_div.sv =====
// ----------------------------------------------------------------------------
// vcd_div
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// ----------------------------------------------------------------------------
module vcd_div import vcd_pkg::*; #(
	parameter int NW = 86,
	parameter int DW = 62
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	output logic          out_vld,
	output logic [NW-1:0] out_quo
);

	logic [NW-1:0] vld_s;
	logic [DW-1:0] rem_s [NW];
	logic [DW-1:0] den_s [NW];
	logic [NW-1:0] num_s [NW];
	logic [NW-1:0] quo_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stg
		logic          vld_i;
		logic [DW-1:0] rem_i;
		logic [DW-1:0] den_i;
		logic [NW-1:0] num_i;
		logic [NW-1:0] quo_i;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign vld_i = in_vld;
			assign rem_i = '0;
			assign den_i = in_den;
			assign num_i = in_num;
			assign quo_i = '0;
		end else begin : g_next
			assign vld_i = vld_s[k-1];
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
			assign num_i = num_s[k-1];
			assign quo_i = quo_s[k-1];
		end

		assign trial = {rem_i, num_i[NW-1]};
		assign diff  = trial - {1'b0, den_i};
		assign ge    = (trial >= {1'b0, den_i});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
			den_s[k] <= den_i;
			num_s[k] <= {num_i[NW-2:0], 1'b0};
			quo_s[k] <= {quo_i[NW-2:0], ge};
		end
	end

	assign out_vld = vld_s[NW-1];
	assign out_quo = quo_s[NW-1];

	// remainder ends below the divisor whenever the divisor is nonzero
	a_rem_lt_den: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld && den_s[NW-1] != '0) |-> (rem_s[NW-1] < den_s[NW-1]))
		else $error("divider remainder not below divisor");

endmodule

// ===== sv/vcd_combine.sv =====
// ----------------------------------------------------------------------------
// vcd_combine
// Sums the signed face terms, saturates the source, applies the stage
// coefficients and saturates the new fraction.
// ----------------------------------------------------------------------------
module vcd_combine import vcd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic [NUM_W-1:0]   quo_m,
	input  logic [NUM_W-1:0]   quo_p,
	input  logic [NUM_W-1:0]   quo_y,
	input  side_t              side,
	input  logic signed [31:0] dt_coef_alpha,
	input  logic signed [31:0] dt_coef_beta,
	input  logic               beta_enable,
	output logic               done,
	output logic signed [31:0] source_new,
	output logic signed [31:0] fraction_new,
	output logic               saturated
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	// stage 1: signed x pair and y term
	logic signed [TERM_W-1:0] tm, tp, ty;
	logic signed [TERM_W-1:0] sumx_s1, ty_s1;
	side_t                    side_s1;

	assign tm = side.neg_m ? -$signed({2'b00, quo_m}) : $signed({2'b00, quo_m});
	assign tp = side.neg_p ? -$signed({2'b00, quo_p}) : $signed({2'b00, quo_p});
	assign ty = side.neg_y ? -$signed({2'b00, quo_y}) : $signed({2'b00, quo_y});

	// stage 2: full sum
	logic signed [ACC_W-1:0] acc_s2;
	side_t                   side_s2;

	// stage 3: saturate source
	logic signed [31:0] snew_s3;
	logic               clip_s3;
	side_t              side_s3;
	logic               acc_fits;

	assign acc_fits = (acc_s2[ACC_W-1:31] == {(ACC_W-31){acc_s2[ACC_W-1]}});

	// stage 4: coefficient products
	logic signed [63:0] pa_s4, pb_s4;
	logic signed [31:0] snew_s4, vold_s4;
	logic               clip_s4;

	// stage 5: floor, add, saturate
	logic signed [41:0] vsum;
	logic               vfits;

	assign vsum = 42'(vold_s4) + 42'($signed(pa_s4[63:FRAC_W]))
		+ 42'($signed(pb_s4[63:FRAC_W]));
	assign vfits = (vsum[41:31] == {11{vsum[41]}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		sumx_s1 <= tm + tp;
		ty_s1   <= ty;
		side_s1 <= side;

		acc_s2  <= ACC_W'(sumx_s1) + ACC_W'(ty_s1);
		side_s2 <= side_s1;

		if (acc_fits) begin
			snew_s3 <= acc_s2[31:0];
		end else begin
			snew_s3 <= acc_s2[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		clip_s3 <= !acc_fits;
		side_s3 <= side_s2;

		pa_s4   <= dt_coef_alpha * snew_s3;
		pb_s4   <= beta_enable ? dt_coef_beta * side_s3.sprev : 64'sd0;
		snew_s4 <= snew_s3;
		vold_s4 <= side_s3.vold;
		clip_s4 <= clip_s3;

		source_new <= snew_s4;
		if (vfits) begin
			fraction_new <= vsum[31:0];
		end else begin
			fraction_new <= vsum[41] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		saturated <= clip_s4 || !vfits;
	end

	assign done = vld_s5;

	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && source_new != 32'sh7FFF_FFFF && source_new != 32'sh8000_0000
			&& fraction_new != 32'sh7FFF_FFFF && fraction_new != 32'sh8000_0000)
		|-> !saturated)
		else $error("saturated set with no value at a limit");

endmodule

// ===== sv/vof_cell_divergence_rk_update.sv =====
// ----------------------------------------------------------------------------
// vof_cell_divergence_rk_update
// Per-cell flux-divergence source and Runge-Kutta volume fraction update.
// ----------------------------------------------------------------------------
// One cell word is taken every cycle (busy is always low). The result appears
// on done after the front stage of metric products, the bit-per-stage
// dividers and the vcd_combine stages of summing, saturation and coefficient
// scaling. Results cannot be held off; sample them in the cycle done is high.
// Write the coefficient registers only with the pipeline empty.
module vof_cell_divergence_rk_update import vcd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_wdata,
	input  logic signed [31:0]   flux_x_minus,
	input  logic signed [31:0]   flux_x_plus,
	input  logic signed [31:0]   flux_y_minus,
	input  logic signed [31:0]   flux_y_plus,
	input  logic [30:0]          scale_x_minus,
	input  logic [30:0]          scale_x_plus,
	input  logic [30:0]          scale_y_center,
	input  logic [30:0]          jacobian_minus,
	input  logic [30:0]          jacobian_center,
	input  logic [30:0]          jacobian_plus,
	input  logic signed [31:0]   fraction_old,
	input  logic signed [31:0]   source_previous,
	output logic                 done,
	output logic signed [31:0]   source_new,
	output logic signed [31:0]   fraction_new,
	output logic                 saturated
);

	localparam int LAT = NUM_W + 6;

	logic signed [31:0] alpha_q, beta_q;
	logic               ben_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
			beta_q  <= '0;
			ben_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALPHA: alpha_q <= cfg_wdata;
				REG_BETA:  beta_q  <= cfg_wdata;
				REG_BEN:   ben_q   <= cfg_wdata[0];
				default:   ;
			endcase
		end
	end

	assign busy = 1'b0;

	// front stage: magnitudes and metric products
	logic [31:0]        mag_m, mag_p;
	logic signed [32:0] dy;
	logic [32:0]        ymag;
	logic [62:0]        pm_full, pp_full;
	logic [61:0]        dm_full, dp_full;

	assign mag_m = flux_x_minus[31] ? 32'(-flux_x_minus) : 32'(flux_x_minus);
	assign mag_p = flux_x_plus[31] ? 32'(-flux_x_plus) : 32'(flux_x_plus);
	assign dy    = 33'(flux_y_minus) - 33'(flux_y_plus);
	assign ymag  = dy[32] ? 33'(-dy) : 33'(dy);
	assign pm_full = mag_m * pos31(jacobian_minus);
	assign pp_full = mag_p * pos31(jacobian_plus);
	assign dm_full = pos31(scale_x_minus) * pos31(jacobian_center);
	assign dp_full = pos31(scale_x_plus) * pos31(jacobian_center);

	logic              vld_s1;
	logic [PROD_W-1:0] pm_s1, pp_s1, dm_s1, dp_s1;
	logic [32:0]       ymag_s1;
	logic [30:0]       hy_s1;
	side_t             side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		pm_s1         <= pm_full[PROD_W-1:0];
		pp_s1         <= pp_full[PROD_W-1:0];
		dm_s1         <= dm_full;
		dp_s1         <= dp_full;
		ymag_s1       <= ymag;
		hy_s1         <= pos31(scale_y_center);
		side_s1.neg_m <= flux_x_minus[31];
		side_s1.neg_p <= !flux_x_plus[31];
		side_s1.neg_y <= dy[32];
		side_s1.vold  <= fraction_old;
		side_s1.sprev <= source_previous;
	end

	// three dividers in lockstep
	logic             vld_dm, vld_dp, vld_dy;
	logic [NUM_W-1:0] quo_m, quo_p, quo_y;

	vcd_div #(.NW(NUM_W), .DW(DEN_W)) u_div_m (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s1),
		.in_num({pm_s1, {FRAC_W{1'b0}}}), .in_den(dm_s1),
		.out_vld(vld_dm), .out_quo(quo_m)
	);

	vcd_div #(.NW(NUM_W), .DW(DEN_W)) u_div_p (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s1),
		.in_num({pp_s1, {FRAC_W{1'b0}}}), .in_den(dp_s1),
		.out_vld(vld_dp), .out_quo(quo_p)
	);

	vcd_div #(.NW(NUM_W), .DW(DEN_W)) u_div_y (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s1),
		.in_num({{(NUM_W-33-FRAC_W){1'b0}}, ymag_s1, {FRAC_W{1'b0}}}),
		.in_den({{(DEN_W-31){1'b0}}, hy_s1}),
		.out_vld(vld_dy), .out_quo(quo_y)
	);

	// sideband delay matched to the divider depth
	side_t side_dly_q [NUM_W];

	always_ff @(posedge clk) begin
		side_dly_q[0] <= side_s1;
		for (int i = 1; i < NUM_W; i++) begin
			side_dly_q[i] <= side_dly_q[i-1];
		end
	end

	vcd_combine u_combine (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_dm),
		.quo_m(quo_m), .quo_p(quo_p), .quo_y(quo_y),
		.side(side_dly_q[NUM_W-1]),
		.dt_coef_alpha(alpha_q), .dt_coef_beta(beta_q), .beta_enable(ben_q),
		.done(done), .source_new(source_new),
		.fraction_new(fraction_new), .saturated(saturated)
	);

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_dm == vld_dp) && (vld_dm == vld_dy))
		else $error("dividers out of step");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && arst_n, LAT))
		else $error("result word without matching start");

endmodule
